// ----- rtl/mcsd_pkg.sv -----
// Shared types and constants for the multi-channel sensor debounce block.
`default_nettype none

package mcsd_pkg;

   localparam int CODE_WIDTH      = 24;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int DEF_CHANNELS    = 24;
   localparam int DEF_COUNT_WIDTH = 16;

   localparam logic [CSR_DATA_WIDTH-1:0] LOAD_VALUE_RESET    = 16'd10;
   localparam logic [CSR_DATA_WIDTH-1:0] SETTLED_VALUE_RESET = 16'd0;
   localparam logic                      ACTIVE_LEVEL_RESET  = 1'b0;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_LEVEL  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOAD_VALUE    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETTLED_VALUE = 2'd2;

   localparam logic REQ_SCAN = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [CODE_WIDTH-1:0] sensor_bits;
   } req_payload_type;

   typedef struct packed {
      logic                  changed;
      logic [CODE_WIDTH-1:0] stable_code;
   } rsp_payload_type;

   // Per-request control broadcast to every lane.
   typedef struct packed {
      logic scan;
      logic tick;
      logic active_level;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/mcsd_lane.sv -----
// One debounce lane: countdown counter and stable bit for a single sensor line.
`default_nettype none

module mcsd_lane #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mcsd_pkg::lane_ctrl_type ctrl,
   input  wire logic                   level,
   input  wire logic [COUNT_WIDTH-1:0] load_cnt,
   input  wire logic [COUNT_WIDTH-1:0] settled_cnt,
   output logic                        stable_in,
   output logic                        stable_ff
);
   import mcsd_pkg::*;

   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [COUNT_WIDTH-1:0] cnt_in;
   logic                   triggered;

   assign triggered = (level == ctrl.active_level);

   always_comb begin
      cnt_in    = cnt_ff;
      stable_in = stable_ff;
      if (ctrl.tick) begin
         if (cnt_ff > settled_cnt) begin
            cnt_in = cnt_ff - COUNT_WIDTH'(1);
         end
      end else if (ctrl.scan) begin
         if (triggered) begin
            // zero check wins over the settled check
            if (cnt_ff == '0) begin
               cnt_in = load_cnt;
            end else if (cnt_ff == settled_cnt) begin
               stable_in = 1'b1;
            end
         end else begin
            cnt_in    = '0;
            stable_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         stable_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         stable_ff <= stable_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mcsd_merge.sv -----
// Merge stage: gathers lane bits into the stable code, flags changes, holds the response.
`default_nettype none

module mcsd_merge #(
   parameter int CHANNELS = 24
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_accept,
   input  wire logic                    req_scan,
   input  wire logic [CHANNELS-1:0]     lane_stable_in,
   input  wire logic [CHANNELS-1:0]     lane_stable_ff,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output mcsd_pkg::rsp_payload_type    rsp_payload,
   output logic                         req_ready
);
   import mcsd_pkg::*;

   logic [CODE_WIDTH-1:0] code_in;
   logic [CODE_WIDTH-1:0] code_cur;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_payload_type       rsp_payload_ff;
   rsp_payload_type       rsp_payload_in;

   // Lines beyond the code width are dropped; missing lanes read as zero.
   for (genvar j = 0; j < CODE_WIDTH; j++) begin : g_code
      if (j < CHANNELS) begin : g_lane
         assign code_in[j]  = lane_stable_in[j];
         assign code_cur[j] = lane_stable_ff[j];
      end else begin : g_none
         assign code_in[j]  = 1'b0;
         assign code_cur[j] = 1'b0;
      end
   end

   assign req_ready = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_payload_in.changed     = req_scan & (code_in != code_cur);
      rsp_payload_in.stable_code = code_in;
      rsp_valid_in               = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ----- rtl/multi_channel_sensor_debounce.sv -----
// Top level of the multi-channel sensor debounce block.
//
// Debounces CHANNELS sensor lines with one countdown counter per line. Each
// request is either a scan of the lines or a timer tick; every request yields
// exactly one response with the stable code and a changed flag. All lanes
// update side by side in the cycle a request is accepted, and the response
// comes out of a register in the following cycle, so the block takes one request per
// cycle as long as responses are taken; the single response register is what
// sets that figure. Configuration writes are always accepted and take effect
// on the next request.
`default_nettype none

module multi_channel_sensor_debounce #(
   parameter int CHANNELS    = mcsd_pkg::DEF_CHANNELS,
   parameter int COUNT_WIDTH = mcsd_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire mcsd_pkg::req_payload_type              req_payload,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output mcsd_pkg::rsp_payload_type                   rsp_payload,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [mcsd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [mcsd_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import mcsd_pkg::*;

   logic                      active_level_ff;
   logic                      active_level_in;
   logic [CSR_DATA_WIDTH-1:0] load_value_ff;
   logic [CSR_DATA_WIDTH-1:0] load_value_in;
   logic [CSR_DATA_WIDTH-1:0] settled_value_ff;
   logic [CSR_DATA_WIDTH-1:0] settled_value_in;
   logic [COUNT_WIDTH-1:0]    load_cnt;
   logic [COUNT_WIDTH-1:0]    settled_cnt;
   logic                      req_accept;
   lane_ctrl_type             lane_ctrl;
   logic [CHANNELS-1:0]       lane_stable_in;
   logic [CHANNELS-1:0]       lane_stable_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      active_level_in  = active_level_ff;
      load_value_in    = load_value_ff;
      settled_value_in = settled_value_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ACTIVE_LEVEL:  active_level_in  = csr_data[0];
            CSR_LOAD_VALUE:    load_value_in    = csr_data;
            CSR_SETTLED_VALUE: settled_value_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff  <= ACTIVE_LEVEL_RESET;
         load_value_ff    <= LOAD_VALUE_RESET;
         settled_value_ff <= SETTLED_VALUE_RESET;
      end else begin
         active_level_ff  <= active_level_in;
         load_value_ff    <= load_value_in;
         settled_value_ff <= settled_value_in;
      end
   end

   // Fit the configured values to the counter width.
   assign load_cnt    = COUNT_WIDTH'(load_value_ff);
   assign settled_cnt = COUNT_WIDTH'(settled_value_ff);

   assign req_accept             = req_valid & req_ready;
   assign lane_ctrl.scan         = req_accept & (req_payload.req_type == REQ_SCAN);
   assign lane_ctrl.tick         = req_accept & (req_payload.req_type == REQ_TICK);
   assign lane_ctrl.active_level = active_level_ff;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic level;
      if (i < CODE_WIDTH) begin : g_wired
         assign level = req_payload.sensor_bits[i];
      end else begin : g_open
         assign level = 1'b0;
      end

      mcsd_lane #(
         .COUNT_WIDTH(COUNT_WIDTH)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (lane_ctrl),
         .level       (level),
         .load_cnt    (load_cnt),
         .settled_cnt (settled_cnt),
         .stable_in   (lane_stable_in[i]),
         .stable_ff   (lane_stable_ff[i])
      );
   end

   mcsd_merge #(
      .CHANNELS(CHANNELS)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_accept),
      .req_scan       (lane_ctrl.scan),
      .lane_stable_in (lane_stable_in),
      .lane_stable_ff (lane_stable_ff),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .req_ready      (req_ready)
   );

endmodule

`default_nettype wire

// ----- rtl/mcsd_checker.sv -----
// Port-level checker for the sensor debounce block, bound to the top level.
`default_nettype none

module mcsd_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire mcsd_pkg::req_payload_type req_payload,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire mcsd_pkg::rsp_payload_type rsp_payload
);
   import mcsd_pkg::*;

   // A stalled response must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // Every accepted request shows a response on the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   // A tick never reports a change.
   a_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.req_type == REQ_TICK
      |=> !rsp_payload.changed)
      else $error("tick response flagged a change");

   // Ready only drops behind a waiting response.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

endmodule

bind multi_channel_sensor_debounce mcsd_checker u_mcsd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
